[rtl/email_address_syntax_checker_unit_defines.svh]
// Assertion macros for the email address syntax checker.
// Used by the top level only; no other dependencies.
`ifndef EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EASCU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("eascu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define EASCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("eascu: next-cycle check failed");

`endif

[rtl/eascu_pkg.sv]
// Shared types, phase codes and byte classification for the address checker.
// No dependencies.
package eascu_pkg;

    localparam int MAX_LEN = 256;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [2:0]       t_phase;

    localparam t_phase PH_LOCAL  = 3'd0;
    localparam t_phase PH_QUOTED = 3'd1;
    localparam t_phase PH_QESC   = 3'd2;
    localparam t_phase PH_QCLOSE = 3'd3;
    localparam t_phase PH_DOMAIN = 3'd4;
    localparam t_phase PH_REJECT = 3'd5;
    localparam t_phase PH_ACCEPT = 3'd6;

    localparam t_byte CH_NUL    = 8'd0;
    localparam t_byte CH_SPACE  = 8'd32;
    localparam t_byte CH_QUOTE  = 8'd34;
    localparam t_byte CH_DOT    = 8'd46;
    localparam t_byte CH_AT     = 8'd64;
    localparam t_byte CH_BSLASH = 8'd92;
    localparam t_byte CH_DEL    = 8'd127;

    function automatic logic is_special(input t_byte b);
        return b inside {8'd40, 8'd41, 8'd60, 8'd62, 8'd64, 8'd44, 8'd59, 8'd58,
                         8'd34, 8'd91, 8'd93};
    endfunction

    function automatic logic is_final(input t_phase ph);
        return (ph == PH_REJECT) || (ph == PH_ACCEPT);
    endfunction

    // Verdict at end of string from a non-final phase.
    function automatic t_phase finish(input t_phase ph, input logic dom_empty,
                                      input logic prev_dot, input logic dot_seen);
        return (ph == PH_DOMAIN && !dom_empty && !prev_dot && dot_seen) ?
               PH_ACCEPT : PH_REJECT;
    endfunction

endpackage

[rtl/eascu_byte_if.sv]
// Byte channel: valid/ready handshake carrying one address byte and a last flag.
// Depends on eascu_pkg.
interface eascu_byte_if;
    logic             valid;
    logic             ready;
    eascu_pkg::t_byte ch;
    logic             last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

[rtl/eascu_verdict_if.sv]
// Verdict channel: valid/ready handshake carrying one accept/reject bit.
// No dependencies.
interface eascu_verdict_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, accepted, input ready);
    modport sink   (input valid, accepted, output ready);
endinterface

[rtl/email_address_syntax_checker_unit.sv]
// Email address syntax checker.
// Channels: i_byte takes one address byte per transfer (ch, last); o_verdict
// gives one transfer (accepted) for each byte that carries last = 1.
// A byte 0 or MAX_LEN bytes end the string; later bytes up to last are
// consumed without effect. After each verdict all parsing state returns to
// its start values, ready for the next address.
// A byte sits in the input register after the edge that takes it, and the
// parse state and verdict register update on the edge on which it leaves
// that register; the verdict is offered from the verdict register.
// Throughput: one byte per cycle, sustained while no last byte waits on a
// pending verdict; the parse state update is a single pass of byte compares
// and a counter increment per cycle.
// Stall: while o_verdict waits on ready, bytes without last keep flowing;
// a second last byte holds in the input register and i_byte.ready drops
// until the pending verdict transfers.
// Reset: i_rst_n is synchronous, active low; it empties both registers and
// returns the parse state to the start of an address.
// Depends on eascu_pkg, eascu_byte_if, eascu_verdict_if and the defines header.
`include "email_address_syntax_checker_unit_defines.svh"

module email_address_syntax_checker_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    eascu_byte_if.sink             i_byte,
    eascu_verdict_if.source        o_verdict
);
    import eascu_pkg::*;

    // Input register
    logic   r_in_valid;
    t_byte  r_ch;
    logic   r_last;

    // Parse state
    t_phase r_phase,           n_phase;
    logic   r_local_empty,     n_local_empty;
    logic   r_prev_dot,        n_prev_dot;
    logic   r_domain_empty,    n_domain_empty;
    logic   r_domain_dot_seen, n_domain_dot_seen;
    t_count r_byte_count,      n_byte_count;

    // Result register
    logic   r_out_valid;
    logic   r_accepted,        n_accepted;

    // Intermediate state after taking the byte, before the verdict
    t_phase s_phase;
    logic   s_local_empty, s_prev_dot, s_domain_empty, s_dot_seen;
    t_count s_count;

    logic   advance;

    // A non-last byte never touches the result register, so it moves freely.
    assign advance      = r_in_valid && (!r_last || !r_out_valid || o_verdict.ready);
    assign i_byte.ready = !r_in_valid || advance;

    assign o_verdict.valid    = r_out_valid;
    assign o_verdict.accepted = r_accepted;

    always_comb begin
        s_phase        = r_phase;
        s_local_empty  = r_local_empty;
        s_prev_dot     = r_prev_dot;
        s_domain_empty = r_domain_empty;
        s_dot_seen     = r_domain_dot_seen;
        s_count        = r_byte_count;

        if (!is_final(r_phase) && r_byte_count < t_count'(MAX_LEN)) begin
            s_count = r_byte_count + t_count'(1);
            if (r_ch == CH_NUL) begin
                s_phase = finish(r_phase, r_domain_empty, r_prev_dot, r_domain_dot_seen);
            end else begin
                case (r_phase)
                    PH_LOCAL: begin
                        if (r_ch == CH_QUOTE && (r_local_empty || r_prev_dot)) begin
                            s_phase       = PH_QUOTED;
                            s_local_empty = 1'b0;
                            s_prev_dot    = 1'b0;
                        end else if (r_ch == CH_AT) begin
                            if (r_local_empty || r_prev_dot) begin
                                s_phase = PH_REJECT;
                            end else begin
                                s_phase    = PH_DOMAIN;
                                s_prev_dot = 1'b0;
                            end
                        end else if (r_ch <= CH_SPACE || r_ch > CH_DEL || is_special(r_ch)) begin
                            s_phase = PH_REJECT;
                        end else begin
                            s_local_empty = 1'b0;
                            s_prev_dot    = (r_ch == CH_DOT);
                        end
                    end
                    PH_QUOTED: begin
                        if (r_ch == CH_QUOTE) begin
                            s_phase = PH_QCLOSE;
                        end else if (r_ch == CH_BSLASH) begin
                            s_phase = PH_QESC;
                        end else if (r_ch <= CH_SPACE || r_ch > CH_DEL) begin
                            s_phase = PH_REJECT;
                        end
                    end
                    PH_QESC: begin
                        s_phase = (r_ch >= CH_SPACE && r_ch <= CH_DEL) ? PH_QUOTED : PH_REJECT;
                    end
                    PH_QCLOSE: begin
                        if (r_ch == CH_AT) begin
                            s_phase    = PH_DOMAIN;
                            s_prev_dot = 1'b0;
                        end else if (r_ch == CH_DOT) begin
                            s_phase    = PH_LOCAL;
                            s_prev_dot = 1'b1;
                        end else begin
                            s_phase = PH_REJECT;
                        end
                    end
                    PH_DOMAIN: begin
                        if (r_ch == CH_DOT) begin
                            if (r_domain_empty || r_prev_dot) begin
                                s_phase = PH_REJECT;
                            end else begin
                                s_dot_seen = 1'b1;
                                s_prev_dot = 1'b1;
                            end
                        end else if (r_ch <= CH_SPACE || r_ch >= CH_DEL || is_special(r_ch)) begin
                            s_phase = PH_REJECT;
                        end else begin
                            s_domain_empty = 1'b0;
                            s_prev_dot     = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (is_final(s_phase)) begin
            n_accepted = (s_phase == PH_ACCEPT);
        end else begin
            n_accepted = (finish(s_phase, s_domain_empty, s_prev_dot, s_dot_seen) == PH_ACCEPT);
        end

        // Drop back to the start of an address once a verdict is given.
        if (r_last) begin
            n_phase           = PH_LOCAL;
            n_local_empty     = 1'b1;
            n_prev_dot        = 1'b0;
            n_domain_empty    = 1'b1;
            n_domain_dot_seen = 1'b0;
            n_byte_count      = '0;
        end else begin
            n_phase           = s_phase;
            n_local_empty     = s_local_empty;
            n_prev_dot        = s_prev_dot;
            n_domain_empty    = s_domain_empty;
            n_domain_dot_seen = s_dot_seen;
            n_byte_count      = s_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_phase           <= PH_LOCAL;
            r_local_empty     <= 1'b1;
            r_prev_dot        <= 1'b0;
            r_domain_empty    <= 1'b1;
            r_domain_dot_seen <= 1'b0;
            r_byte_count      <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (advance) begin
                r_phase           <= n_phase;
                r_local_empty     <= n_local_empty;
                r_prev_dot        <= n_prev_dot;
                r_domain_empty    <= n_domain_empty;
                r_domain_dot_seen <= n_domain_dot_seen;
                r_byte_count      <= n_byte_count;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_verdict.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_ch   <= i_byte.ch;
            r_last <= i_byte.last;
        end
        if (advance && r_last) begin
            r_accepted <= n_accepted;
        end
    end

    `EASCU_ASSERT_NEXT(a_verdict_follows_last, i_clk, i_rst_n, advance && r_last, r_out_valid)
    `EASCU_ASSERT_NEXT(a_state_restarts, i_clk, i_rst_n, advance && r_last,
                       r_phase == PH_LOCAL && r_byte_count == '0 && r_domain_empty)
    `EASCU_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_byte_count <= t_count'(MAX_LEN))
    `EASCU_ASSERT_NOW(a_accept_needs_dot, i_clk, i_rst_n, r_phase == PH_ACCEPT,
                      r_domain_dot_seen && !r_domain_empty)

endmodule

[tb/tb_email_address_syntax_checker_unit.sv]
// Self-checking testbench for the byte-serial email address syntax checker.
// Predicts each verdict from the bytes transferred in and checks them in order.
// Depends on eascu_pkg, eascu_byte_if, eascu_verdict_if and the top level.
module tb_email_address_syntax_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import eascu_pkg::*;

    localparam int RANDOM_BYTES = 1300;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    eascu_byte_if    byte_ch ();
    eascu_verdict_if verdict_ch ();

    email_address_syntax_checker_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_ch),
        .o_verdict (verdict_ch)
    );

    function automatic bit reserved_char(input t_byte b);
        return b == "(" || b == ")" || b == "<" || b == ">" || b == CH_AT ||
               b == "," || b == ";" || b == ":" || b == CH_QUOTE ||
               b == "[" || b == "]";
    endfunction

    // Tracks the parse of the current address and holds the verdicts owed.
    class verdict_board;
        t_phase phase;
        bit     lp_empty;
        bit     after_dot;
        bit     dom_empty;
        bit     dom_dot;
        int     taken;
        bit     owed[$];
        int     errors;
        int     n_accept;
        int     n_reject;
        int     n_bytes;

        function new();
            restart();
            errors   = 0;
            n_accept = 0;
            n_reject = 0;
            n_bytes  = 0;
        endfunction

        function void restart();
            phase     = PH_LOCAL;
            lp_empty  = 1'b1;
            after_dot = 1'b0;
            dom_empty = 1'b1;
            dom_dot   = 1'b0;
            taken     = 0;
        endfunction

        function bit settled();
            return phase == PH_REJECT || phase == PH_ACCEPT;
        endfunction

        function void end_of_string();
            if (phase == PH_DOMAIN && !dom_empty && !after_dot && dom_dot) begin
                phase = PH_ACCEPT;
            end else begin
                phase = PH_REJECT;
            end
        endfunction

        function void advance(input t_byte b);
            case (phase)
                PH_LOCAL: begin
                    if (b == CH_QUOTE && (lp_empty || after_dot)) begin
                        phase     = PH_QUOTED;
                        lp_empty  = 1'b0;
                        after_dot = 1'b0;
                    end else if (b == CH_AT) begin
                        if (lp_empty || after_dot) begin
                            phase = PH_REJECT;
                        end else begin
                            phase     = PH_DOMAIN;
                            after_dot = 1'b0;
                        end
                    end else if (b <= CH_SPACE || b > CH_DEL || reserved_char(b)) begin
                        phase = PH_REJECT;
                    end else begin
                        lp_empty  = 1'b0;
                        after_dot = (b == CH_DOT);
                    end
                end
                PH_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        phase = PH_QCLOSE;
                    end else if (b == CH_BSLASH) begin
                        phase = PH_QESC;
                    end else if (b <= CH_SPACE || b > CH_DEL) begin
                        phase = PH_REJECT;
                    end
                end
                PH_QESC: begin
                    phase = (b >= CH_SPACE && b <= CH_DEL) ? PH_QUOTED : PH_REJECT;
                end
                PH_QCLOSE: begin
                    if (b == CH_AT) begin
                        phase     = PH_DOMAIN;
                        after_dot = 1'b0;
                    end else if (b == CH_DOT) begin
                        phase     = PH_LOCAL;
                        after_dot = 1'b1;
                    end else begin
                        phase = PH_REJECT;
                    end
                end
                PH_DOMAIN: begin
                    if (b == CH_DOT) begin
                        if (dom_empty || after_dot) begin
                            phase = PH_REJECT;
                        end else begin
                            dom_dot   = 1'b1;
                            after_dot = 1'b1;
                        end
                    end else if (b <= CH_SPACE || b >= CH_DEL || reserved_char(b)) begin
                        phase = PH_REJECT;
                    end else begin
                        dom_empty = 1'b0;
                        after_dot = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void take_byte(input t_byte b, input logic is_last);
            n_bytes++;
            if (!settled() && taken < MAX_LEN) begin
                taken++;
                if (b == CH_NUL) begin
                    end_of_string();
                end else begin
                    advance(b);
                end
            end
            if (is_last) begin
                if (!settled()) begin
                    end_of_string();
                end
                owed.push_back(phase == PH_ACCEPT);
                restart();
            end
        endfunction

        function void check_verdict(input logic acc);
            bit want;
            if (owed.size() == 0) begin
                $display("%0t: verdict %0b arrived with none outstanding", $time, acc);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (acc !== want) begin
                $display("%0t: verdict mismatch, expected %0b, got %0b", $time, want, acc);
                errors++;
            end
            if (acc === 1'b1) begin
                n_accept++;
            end else begin
                n_reject++;
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    verdict_board board = new();
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int cycles         = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input t_byte c, input logic is_last);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.ch    <= c;
        byte_ch.last  <= is_last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        board.take_byte(c, is_last);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit with_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(t_byte'(s[i]), with_last && i == s.len() - 1);
        end
    endtask

    task automatic send_address(input t_byte q[$]);
        for (int i = 0; i < q.size(); i++) begin
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    // Hold the input idle until every owed verdict has transferred.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
    endtask

    function automatic t_byte atom_char();
        t_byte b;
        do b = t_byte'($urandom_range(33, 127)); while (reserved_char(b) || b == CH_DOT);
        return b;
    endfunction

    function automatic t_byte label_char();
        t_byte b;
        do b = t_byte'($urandom_range(33, 126)); while (reserved_char(b) || b == CH_DOT);
        return b;
    endfunction

    function automatic t_byte quoted_char();
        t_byte b;
        do b = t_byte'($urandom_range(33, 127)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic t_byte structural_char();
        case ($urandom_range(0, 3))
            0:       return CH_QUOTE;
            1:       return CH_DOT;
            2:       return CH_AT;
            default: return CH_BSLASH;
        endcase
    endfunction

    // Well-formed address with random content, then an occasional corruption.
    function automatic void build_address(ref t_byte q[$], input bit go_long);
        int nseg;
        int nlab;
        int pos;
        q.delete();
        nseg = go_long ? 1 : $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
            if (s > 0) q.push_back(CH_DOT);
            if (go_long) begin
                repeat ($urandom_range(240, 262)) q.push_back(atom_char());
            end else if ($urandom_range(0, 3) == 0) begin
                q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        q.push_back(CH_BSLASH);
                        q.push_back(t_byte'($urandom_range(32, 127)));
                    end else begin
                        q.push_back(quoted_char());
                    end
                end
                q.push_back(CH_QUOTE);
            end else begin
                repeat ($urandom_range(1, 6)) q.push_back(atom_char());
            end
        end
        q.push_back(CH_AT);
        nlab = $urandom_range(1, 3);
        for (int l = 0; l < nlab; l++) begin
            if (l > 0) q.push_back(CH_DOT);
            repeat ($urandom_range(1, 5)) q.push_back(label_char());
        end
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 9))
            6: q[pos] = t_byte'($urandom_range(0, 255));
            7: q.insert(pos, $urandom_range(0, 1) ? structural_char()
                                                  : t_byte'($urandom_range(0, 255)));
            8: begin
                if ($urandom_range(0, 1)) begin
                    q.delete(pos);
                end else begin
                    while (q.size() > pos + 1) q.pop_back();
                end
            end
            9: begin
                q.push_back(CH_NUL);
                repeat ($urandom_range(0, 3)) q.push_back(t_byte'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void build_noise(ref t_byte q[$]);
        q.delete();
        repeat ($urandom_range(1, 8)) begin
            q.push_back($urandom_range(0, 1) ? structural_char()
                                             : t_byte'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        int   seen;
        int   stall;
        verdict_ch.ready = 1'b0;
        seen = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 9) == 0) receiver_idles = !receiver_idles;
            stall = receiver_idles ? $urandom_range(0, 15) : 0;
            // Long hold-off lets the block fill and stall its input.
            if (seen == 20 || seen == 70) stall = LONG_HOLD;
            if (stall > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge i_clk); while (verdict_ch.valid !== 1'b1);
            board.check_verdict(verdict_ch.accepted);
            seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        t_byte addr[$];
        int    n_addr;
        i_rst_n       = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.ch    = CH_NUL;
        byte_ch.last  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("a@b.c", 1'b1);
        send_text("\"\\ \"@b.c", 1'b1);
        send_text(".a..b@c.d", 1'b1);
        send_text("ab", 1'b1);
        // String ends at the NUL; bytes after it are ignored.
        send_text("a@b.c", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(CH_NUL, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        n_addr = 0;
        while (board.n_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) sender_idles = !sender_idles;
            if ($urandom_range(0, 9) == 0) begin
                build_noise(addr);
            end else begin
                build_address(addr, n_addr % 50 == 25);
            end
            send_address(addr);
            n_addr++;
            if (n_addr == 40) wait_drained();
        end

        byte_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.outstanding() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, board.outstanding());
            board.errors++;
        end

        $display("Run covered %0d bytes in %0d random addresses plus directed cases,",
                 board.n_bytes, n_addr);
        $display("giving %0d accepted and %0d rejected verdicts, %0d mismatches.",
                 board.n_accept, board.n_reject, board.errors);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
